// ----- rtl/pdp_pkg.sv -----
// shared types, register codes and helpers for the depth pixel to point block
package pdp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_FOCAL_X     = 3'd2;
  localparam logic [2:0] REG_FOCAL_Y     = 3'd3;
  localparam logic [2:0] REG_DEPTH_SCALE = 3'd4;

  // register reset values, unsigned Q12.4
  localparam logic [15:0] CENTER_X_RST    = 16'd10240;
  localparam logic [15:0] CENTER_Y_RST    = 16'd5760;
  localparam logic [15:0] FOCAL_X_RST     = 16'd11200;
  localparam logic [15:0] FOCAL_Y_RST     = 16'd11200;
  localparam logic [15:0] DEPTH_SCALE_RST = 16'd16000;

  // raw depth value that marks a missing sample
  localparam logic [15:0] NO_DEPTH_MARK = 16'd4096;

  // datapath widths
  localparam int unsigned ZW = 36;      // depth * 2^20 / scale
  localparam int unsigned PW = ZW + 16; // offset magnitude times z

  // saturation limits of the Q24.16 outputs
  localparam logic [PW-1:0] POS_LIMIT = PW'(64'h7F_FFFF_FFFF);
  localparam logic [PW-1:0] NEG_LIMIT = PW'(64'h80_0000_0000);

  typedef struct packed {
    logic [10:0] pixel_row;
    logic [10:0] pixel_col;
    logic [15:0] raw_depth;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
  } pdp_pixel_t;

  typedef struct packed {
    logic signed [39:0] point_x;
    logic signed [39:0] point_y;
    logic [38:0]        point_z;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
  } pdp_point_t;

  // zero divisor is treated as one
  function automatic logic [15:0] nonzero(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // clamp a magnitude and apply its sign, 40-bit two's complement
  function automatic logic [39:0] saturate(input logic neg, input logic [PW-1:0] q);
    logic [PW-1:0] m;
    if (neg) begin
      m = (q > NEG_LIMIT) ? NEG_LIMIT : q;
      return 40'd0 - m[39:0];
    end else begin
      m = (q > POS_LIMIT) ? POS_LIMIT : q;
      return m[39:0];
    end
  endfunction

endpackage

// ----- rtl/pdp_if.sv -----
// valid/ready channels for pixels, points and register writes
interface pdp_pixel_if;
  logic                valid;
  logic                ready;
  pdp_pkg::pdp_pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pdp_point_if;
  logic                valid;
  logic                ready;
  pdp_pkg::pdp_point_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pdp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/pdp_div.sv -----
// pipelined restoring divider, two quotient bits per stage, with side payload
module pdp_div #(
  parameter int unsigned DW = 36,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          vld_i,
  input  logic [DW-1:0] num_i,
  input  logic [15:0]   den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [DW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned NS = (DW + 1) / 2;
  localparam int unsigned AW = 2 * NS;

  logic [AW-1:0] acc_q  [NS];
  logic [15:0]   rem_q  [NS];
  logic [SW-1:0] side_q [NS];
  logic          vld_q  [NS];

  // two shift-compare-subtract steps; remainder stays below the divisor
  function automatic logic [16+AW-1:0] step2(input logic [15:0] rem,
                                             input logic [AW-1:0] acc,
                                             input logic [15:0] den);
    logic [16:0]   r;
    logic [15:0]   rr;
    logic [AW-1:0] a;
    rr = rem;
    a  = acc;
    for (int k = 0; k < 2; k++) begin
      r = {rr, a[AW-1]};
      a = {a[AW-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        a[0] = 1'b1;
      end
      rr = r[15:0];
    end
    return {rr, a};
  endfunction

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [AW-1:0]      acc_in;
    logic [15:0]        rem_in;
    logic [SW-1:0]      side_in;
    logic               vld_in;
    logic [16+AW-1:0]   nxt;

    if (s == 0) begin : g_first
      assign acc_in  = AW'(num_i);
      assign rem_in  = 16'd0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign acc_in  = acc_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign nxt = step2(rem_in, acc_in, den_i);

    // valid bit of the stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_in;
      end
    end

    // stage payload
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= nxt[16+AW-1:AW];
        acc_q[s]  <= nxt[AW-1:0];
        side_q[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign quo_o  = acc_q[NS-1][DW-1:0];
  assign side_o = side_q[NS-1];

endmodule

// ----- rtl/pdp_outbuf.sv -----
// two-entry output buffer that decouples the pipeline from the receiver
module pdp_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pdp_pkg::pdp_point_t data_i,
  output logic                full_o,
  pdp_point_if.source         pt_o
);
  import pdp_pkg::*;

  pdp_point_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop    = pt_o.valid && pt_o.ready;
  assign full_o = (cnt_q == 2'd2);
  assign cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop};

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop)    rp_q <= ~rp_q;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  assign pt_o.valid = (cnt_q != 2'd0);
  assign pt_o.data  = mem_q[rp_q];

endmodule

// ----- rtl/depth_pixel_to_point.sv -----
// top level: pinhole back-projection of depth pixels into coloured points
//
// Pixels enter on pix_i, one item per clock at most, and points leave on
// pt_o; both are valid/ready channels. Intrinsics and depth scale are
// written on cfg_i, which is always ready; the user must write them only
// while no pixel is in flight, which the block does not enforce. A pixel
// with no depth (0 or 4096) or outside the frame is taken and dropped
// without a point. From an accepted pixel to its point on pt_o the path
// runs through 18 stages of the depth divider (36-bit quotient, two bits
// a stage), one multiply stage, 26 stages of the position dividers
// (52-bit quotient) and one output buffer stage. Throughput is one item
// a cycle while the pipeline advances. The pipeline moves as a whole; a
// two-entry output buffer lets it keep taking pixels while a point
// waits, and it halts only when that buffer is full and its last stage
// holds a point. Nothing is lost or repeated across a stall.
// Reset clears all valid bits and the buffer and loads the default
// intrinsics.
module depth_pixel_to_point #(
  parameter int unsigned MAX_COLUMNS = 2048,
  parameter int unsigned MAX_ROWS    = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pdp_cfg_if.sink     cfg_i,
  pdp_pixel_if.sink   pix_i,
  pdp_point_if.source pt_o
);
  import pdp_pkg::*;

  localparam int unsigned XSW = 1 + ZW + 24;

  logic [15:0] center_x_q, center_y_q, focal_x_q, focal_y_q, scale_q;
  logic        adv, buf_full, keep;

  logic          zd_vld;
  logic [ZW-1:0] zd_quo;
  logic [47:0]   zd_side;

  logic          m_vld_q;
  logic [PW-1:0] prod_x_q, prod_y_q;
  logic          neg_x_q, neg_y_q;
  logic [ZW-1:0] z_q;
  logic [23:0]   rgb_q;

  logic [14:0]   px, py;
  logic          neg_x, neg_y;
  logic [15:0]   mag_x, mag_y;

  logic           xd_vld, yd_vld;
  logic [PW-1:0]  xd_quo, yd_quo;
  logic [XSW-1:0] xd_side;
  logic           yd_side;
  pdp_point_t     pt;

  // register writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      focal_x_q  <= FOCAL_X_RST;
      focal_y_q  <= FOCAL_Y_RST;
      scale_q    <= DEPTH_SCALE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CENTER_X:    center_x_q <= cfg_i.data;
        REG_CENTER_Y:    center_y_q <= cfg_i.data;
        REG_FOCAL_X:     focal_x_q  <= cfg_i.data;
        REG_FOCAL_Y:     focal_y_q  <= cfg_i.data;
        REG_DEPTH_SCALE: scale_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the buffer is full and a point waits
  assign adv         = !(xd_vld && yd_vld && buf_full);
  assign pix_i.ready = adv;

  // drop pixels with no depth or outside the frame
  assign keep = (pix_i.data.raw_depth != 16'd0)
             && (pix_i.data.raw_depth != NO_DEPTH_MARK)
             && ({3'd0, pix_i.data.pixel_row} < 14'(MAX_ROWS))
             && ({3'd0, pix_i.data.pixel_col} < 14'(MAX_COLUMNS));

  // z = depth * 2^20 / scale
  pdp_div #(.DW(ZW), .SW(48)) u_zdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (pix_i.valid && keep),
    .num_i  ({pix_i.data.raw_depth, 20'd0}),
    .den_i  (nonzero(scale_q)),
    .side_i ({pix_i.data.pixel_row, pix_i.data.pixel_col, 2'b00,
              pix_i.data.red_in, pix_i.data.green_in, pix_i.data.blue_in}),
    .vld_o  (zd_vld),
    .quo_o  (zd_quo),
    .side_o (zd_side)
  );

  // offsets from the principal point in Q.4
  assign px    = {zd_side[36:26], 4'd0};
  assign py    = {zd_side[47:37], 4'd0};
  assign neg_x = ({1'b0, px} < center_x_q);
  assign neg_y = ({1'b0, py} < center_y_q);
  assign mag_x = neg_x ? (center_x_q - {1'b0, px}) : ({1'b0, px} - center_x_q);
  assign mag_y = neg_y ? (center_y_q - {1'b0, py}) : ({1'b0, py} - center_y_q);

  // multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= zd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_x_q <= PW'(mag_x) * PW'(zd_quo);
      prod_y_q <= PW'(mag_y) * PW'(zd_quo);
      neg_x_q  <= neg_x;
      neg_y_q  <= neg_y;
      z_q      <= zd_quo;
      rgb_q    <= zd_side[23:0];
    end
  end

  // x and y divisions by the focal lengths, in lockstep
  pdp_div #(.DW(PW), .SW(XSW)) u_xdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (m_vld_q),
    .num_i  (prod_x_q),
    .den_i  (nonzero(focal_x_q)),
    .side_i ({neg_x_q, z_q, rgb_q}),
    .vld_o  (xd_vld),
    .quo_o  (xd_quo),
    .side_o (xd_side)
  );

  pdp_div #(.DW(PW), .SW(1)) u_ydiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (m_vld_q),
    .num_i  (prod_y_q),
    .den_i  (nonzero(focal_y_q)),
    .side_i (neg_y_q),
    .vld_o  (yd_vld),
    .quo_o  (yd_quo),
    .side_o (yd_side)
  );

  // saturate and assemble the point
  assign pt.point_x   = saturate(xd_side[XSW-1], xd_quo);
  assign pt.point_y   = saturate(yd_side, yd_quo);
  assign pt.point_z   = 39'(xd_side[ZW+23:24]);
  assign pt.red_out   = xd_side[23:16];
  assign pt.green_out = xd_side[15:8];
  assign pt.blue_out  = xd_side[7:0];

  pdp_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (adv && xd_vld && yd_vld),
    .data_i (pt),
    .full_o (buf_full),
    .pt_o   (pt_o)
  );

endmodule

// ----- rtl/pdp_checker.sv -----
// port-level checks for the depth pixel to point block, bound to the top level
module pdp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic pix_valid_i,
  input logic pix_ready_i,
  input logic pt_valid_i,
  input logic pt_ready_i,
  input logic cfg_ready_i,
  input logic [38:0] pt_z_i
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !pt_valid_i)
    else $error("point valid during reset");

  // input back-pressure only while a point waits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_ready_i |-> pt_valid_i)
    else $error("pixel channel stalled with no point pending");

  // register port never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("configuration port not ready");

  // a waiting point stays and keeps its z value
  a_point_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_valid_i && !pt_ready_i |=> pt_valid_i && $stable(pt_z_i))
    else $error("waiting point dropped or changed");

endmodule

bind depth_pixel_to_point pdp_checker u_pdp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .pt_valid_i  (pt_o.valid),
  .pt_ready_i  (pt_o.ready),
  .cfg_ready_i (cfg_i.ready),
  .pt_z_i      (pt_o.data.point_z)
);

// ----- tb/pdp_tb_if.sv -----
// testbench package: register set mirrored by the scoreboard
package pdp_tb_pkg;
  import pdp_pkg::*;

  // register set mirrored by the checker
  typedef struct {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] focal_x;
    logic [15:0] focal_y;
    logic [15:0] depth_scale;
  } intrinsics_t;
endpackage

// ----- tb/pdp_checker.sv -----
// checker: mirrors the registers, predicts points and compares them
module pdp_scoreboard (
  input  logic           clk_i,
  input  logic           rst_ni,
  pdp_cfg_if             cfg_i,
  pdp_pixel_if           pix_i,
  pdp_point_if           pt_o,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pdp_pkg::*;
  import pdp_tb_pkg::*;

  intrinsics_t    cam;
  pdp_point_t     point_q[$];
  int unsigned    fails;
  int unsigned    pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // offset times depth over focal, truncated toward zero, clamped to 40 bits
  function automatic logic [39:0] back_project(logic [10:0] pix, logic [15:0] ctr,
                                               logic [63:0] z, logic [15:0] foc);
    logic [63:0] p, mag, q, f;
    logic        neg;
    p   = 64'(pix) * 16;
    neg = p < 64'(ctr);
    mag = neg ? 64'(ctr) - p : p - 64'(ctr);
    f   = (foc == 0) ? 64'd1 : 64'(foc);
    q   = (mag * z) / f;
    if (neg) begin
      if (q > 64'h80_0000_0000) q = 64'h80_0000_0000;
      return 40'd0 - q[39:0];
    end
    if (q > 64'h7F_FFFF_FFFF) q = 64'h7F_FFFF_FFFF;
    return q[39:0];
  endfunction

  function automatic void predict_point(pdp_pixel_t px);
    pdp_point_t  pt;
    logic [63:0] z, s;
    if (px.raw_depth == 0 || px.raw_depth == NO_DEPTH_MARK) return;
    s = (cam.depth_scale == 0) ? 64'd1 : 64'(cam.depth_scale);
    z = (64'(px.raw_depth) << 20) / s;
    if (z > 64'h7F_FFFF_FFFF) z = 64'h7F_FFFF_FFFF;
    pt.point_x   = back_project(px.pixel_col, cam.center_x, z, cam.focal_x);
    pt.point_y   = back_project(px.pixel_row, cam.center_y, z, cam.focal_y);
    pt.point_z   = z[38:0];
    pt.red_out   = px.red_in;
    pt.green_out = px.green_in;
    pt.blue_out  = px.blue_in;
    point_q.push_back(pt);
  endfunction

  // watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    pdp_point_t exp_pt;
    if (!rst_ni) begin
      cam.center_x    <= CENTER_X_RST;
      cam.center_y    <= CENTER_Y_RST;
      cam.focal_x     <= FOCAL_X_RST;
      cam.focal_y     <= FOCAL_Y_RST;
      cam.depth_scale <= DEPTH_SCALE_RST;
      fails = 0;
      pending = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_CENTER_X:    cam.center_x    <= cfg_i.data;
          REG_CENTER_Y:    cam.center_y    <= cfg_i.data;
          REG_FOCAL_X:     cam.focal_x     <= cfg_i.data;
          REG_FOCAL_Y:     cam.focal_y     <= cfg_i.data;
          REG_DEPTH_SCALE: cam.depth_scale <= cfg_i.data;
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) predict_point(pix_i.data);
      if (pt_o.valid && pt_o.ready) begin
        if (point_q.size() == 0) begin
          $display("%0t: unexpected point, actual %p", $time, pt_o.data);
          fails++;
        end else begin
          exp_pt = point_q.pop_front();
          if (exp_pt.point_x !== pt_o.data.point_x) begin
            $display("%0t: point_x expected %0d actual %0d", $time,
                     exp_pt.point_x, pt_o.data.point_x);
            fails++;
          end
          if (exp_pt.point_y !== pt_o.data.point_y) begin
            $display("%0t: point_y expected %0d actual %0d", $time,
                     exp_pt.point_y, pt_o.data.point_y);
            fails++;
          end
          if (exp_pt.point_z !== pt_o.data.point_z) begin
            $display("%0t: point_z expected %0d actual %0d", $time,
                     exp_pt.point_z, pt_o.data.point_z);
            fails++;
          end
          if ({exp_pt.red_out, exp_pt.green_out, exp_pt.blue_out} !==
              {pt_o.data.red_out, pt_o.data.green_out, pt_o.data.blue_out}) begin
            $display("%0t: colour expected %h actual %h", $time,
                     {exp_pt.red_out, exp_pt.green_out, exp_pt.blue_out},
                     {pt_o.data.red_out, pt_o.data.green_out, pt_o.data.blue_out});
            fails++;
          end
        end
      end
      pending = point_q.size();
    end
  end
endmodule

// ----- tb/testbench.sv -----
// testbench top: drives pixels and register writes, gives the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pdp_pkg::*;

  localparam int unsigned LATENCY   = 46;
  localparam int unsigned MAX_CYCLE = 400000;
  // register index that maps to no register
  localparam logic [2:0]  REG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count, pending, cycle;
  int unsigned send_idle, recv_idle;

  pdp_cfg_if   cfg_ch();
  pdp_pixel_if pix_ch();
  pdp_point_if pt_ch();

  depth_pixel_to_point u_top (
    .clk_i(clk), .rst_ni(rst_n), .cfg_i(cfg_ch), .pix_i(pix_ch), .pt_o(pt_ch)
  );

  pdp_scoreboard u_chk (
    .clk_i(clk), .rst_ni(rst_n), .cfg_i(cfg_ch), .pix_i(pix_ch), .pt_o(pt_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // random stalls on the point side
  initial pt_ch.ready = 1'b0;
  always @(posedge clk) pt_ch.ready <= ($urandom_range(99) >= recv_idle);

  // run limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // valid stays high after the accepting edge until the next item or an idle cycle
  task automatic send_pixel(logic [10:0] row, logic [10:0] col, logic [15:0] d,
                            logic [23:0] rgb);
    while ($urandom_range(99) < send_idle) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.data  <= '{row, col, d, rgb[23:16], rgb[15:8], rgb[7:0]};
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every point, then for dropped pixels still in the pipe
  task automatic drain();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic set_camera(logic [15:0] cx, logic [15:0] cy, logic [15:0] fx,
                            logic [15:0] fy, logic [15:0] ds);
    drain();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_DEPTH_SCALE, ds);
  endtask

  // mostly valid depths, some no-depth marks and full-range noise
  task automatic random_pixels(int n);
    logic [15:0] d;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: d = 16'd0;
        1: d = NO_DEPTH_MARK;
        2: d = 16'($urandom_range(65535));
        3: d = 16'hFFFF;
        default: d = 16'($urandom_range(8000, 1));
      endcase
      send_pixel(11'($urandom), 11'($urandom), d, 24'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    pix_ch.valid = 1'b0;
    pix_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    send_idle = 20;
    recv_idle = 74;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset intrinsics, field extremes and no-depth marks
    send_pixel(11'd0, 11'd0, 16'd1, 24'h000000);
    send_pixel(11'd2047, 11'd2047, 16'hFFFF, 24'hFFFFFF);
    send_pixel(11'd360, 11'd640, 16'd1000, 24'hA55A3C);
    send_pixel(11'd100, 11'd100, 16'd0, 24'h123456);
    send_pixel(11'd100, 11'd100, NO_DEPTH_MARK, 24'h654321);
    send_pixel(11'd100, 11'd100, 16'd4095, 24'h0F0F0F);
    send_pixel(11'd100, 11'd100, 16'd4097, 24'hF0F0F0);
    // zero divisors and saturation
    set_camera(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_pixel(11'd2047, 11'd2047, 16'hFFFF, 24'h5A5A5A);
    send_pixel(11'd1, 11'd0, 16'd1, 24'h010203);
    set_camera(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1);
    send_pixel(11'd0, 11'd0, 16'hFFFF, 24'hC3C3C3);
    send_pixel(11'd2047, 11'd2047, 16'h8000, 24'h3C3C3C);
    set_camera(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(11'd0, 11'd2047, 16'hFFFF, 24'h808080);
    send_pixel(11'd2047, 11'd0, 16'd1, 24'h7F7F7F);
    drain();
    write_reg(REG_UNUSED, 16'hFFFF); // unknown index, ignored

    // random phases over several camera settings
    set_camera(CENTER_X_RST, CENTER_Y_RST, FOCAL_X_RST, FOCAL_Y_RST, DEPTH_SCALE_RST);
    random_pixels(350);
    set_camera(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)),
               16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)));
    random_pixels(150);
    send_idle = 74;
    recv_idle = 20;
    set_camera(16'd0, 16'd0, 16'd1, 16'd1, 16'd1);
    random_pixels(150);
    set_camera(16'($urandom), 16'($urandom), 16'($urandom_range(200, 1)),
               16'($urandom_range(200, 1)), 16'($urandom_range(65535, 1)));
    random_pixels(300);
    send_idle = 0;
    recv_idle = 0;
    set_camera(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
    random_pixels(250);
    set_camera(CENTER_X_RST, CENTER_Y_RST, FOCAL_X_RST, FOCAL_Y_RST, DEPTH_SCALE_RST);
    random_pixels(230);
    drain();

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
